### hdl/lrs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lrs_pkg
// Shared constants, types and helpers of the reversible LIFO stack.
// ---------------------------------------------------------------------------
package lrs_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = ADDR_W + 2;
    localparam int CMD_W      = 2;
    localparam int VAL_W      = 32;
    localparam int STAT_W     = 2;
    localparam int OCNT_W     = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_REV  = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        t_status           status;
        logic [CNT_W-1:0]  count;
    } t_ptr_resp;

    function automatic logic [ADDR_W-1:0] ring_pos(
        input logic [ADDR_W-1:0] base,
        input logic [CNT_W-1:0]  off,
        input logic              down
    );
        logic [SUM_W-1:0] sum;
        if (down) begin
            sum = SUM_W'(base) + SUM_W'(DEPTH) - SUM_W'(off);
        end else begin
            sum = SUM_W'(base) + SUM_W'(off);
        end
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [VAL_W-1:0] v);
        logic signed [DATA_WIDTH-1:0] w;
        w = DATA_WIDTH'(v);
        return w;
    endfunction

    function automatic logic signed [VAL_W-1:0] from_store(input logic [DATA_WIDTH-1:0] d);
        logic signed [DATA_WIDTH-1:0] w;
        w = d;
        return VAL_W'(w);
    endfunction

endpackage
`default_nettype wire

### hdl/lrs_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lrs_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module lrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### hdl/lrs_ptr.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lrs_ptr
// Base index, entry count and direction; decodes a command into a RAM access.
// ---------------------------------------------------------------------------
module lrs_ptr import lrs_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [CMD_W-1:0] i_cmd,
    output t_ptr_resp             o_resp
);

    logic [ADDR_W-1:0] r_base, n_base;
    logic [CNT_W-1:0]  r_count;
    logic              r_down, n_down;
    logic [ADDR_W-1:0] push_pos;
    logic [ADDR_W-1:0] top_pos;
    t_ptr_resp         resp;

    assign push_pos = ring_pos(r_base, r_count, r_down);
    assign top_pos  = ring_pos(r_base, r_count - CNT_W'(1), r_down);

    always_comb begin
        resp.wr_en  = 1'b0;
        resp.rd_en  = 1'b0;
        resp.addr   = top_pos;
        resp.status = STAT_OK;
        resp.count  = r_count;
        n_base      = r_base;
        n_down      = r_down;
        unique case (t_cmd'(i_cmd))
            CMD_PUSH: begin
                if (r_count >= CNT_W'(DEPTH)) begin
                    resp.status = STAT_FULL;
                end else begin
                    resp.wr_en = 1'b1;
                    resp.addr  = push_pos;
                    resp.count = r_count + CNT_W'(1);
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    resp.status = STAT_EMPTY;
                end else begin
                    resp.rd_en = 1'b1;
                    resp.count = r_count - CNT_W'(1);
                end
            end
            CMD_REV: begin
                if (r_count != '0) begin
                    n_base = top_pos;
                end
                n_down = ~r_down;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_count <= '0;
            r_down  <= 1'b0;
        end else if (i_accept) begin
            r_base  <= n_base;
            r_count <= resp.count;
            r_down  <= n_down;
        end
    end

    assign o_resp = resp;

endmodule
`default_nettype wire

### hdl/reversible_lifo_stack.sv
`default_nettype none
// ---------------------------------------------------------------------------
// reversible_lifo_stack
// Bounded LIFO of signed words over a ring RAM, with push, pop and reverse.
// ---------------------------------------------------------------------------
// Timing: push, reverse and refused commands present the result in the cycle
//   after the transfer; a pop with data goes through the RAM read register.
// Throughput: one command per cycle for push and reverse while the result
//   slot is free; a pop with data holds off input during the registered RAM read.
// Reset: synchronous, active low; clears count, base, direction, the read
//   state and the output valid flag. RAM and result fields are not cleared.
module reversible_lifo_stack import lrs_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic        [CMD_W-1:0]  i_cmd,
    input  wire logic signed [VAL_W-1:0]  i_push_value,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed      [VAL_W-1:0]  o_pop_value,
    output logic             [STAT_W-1:0] o_status,
    output logic                          o_is_empty,
    output logic             [OCNT_W-1:0] o_entry_count
);

    t_state                   r_state, n_state;
    logic                     r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0]  r_pop_value;
    t_status                  r_status;
    logic                     r_is_empty;
    logic        [OCNT_W-1:0] r_count;
    logic                     accept;
    logic                     ld_value;
    logic                     slot_free;
    t_ptr_resp                resp;
    logic [DATA_WIDTH-1:0]    rd_data;

    lrs_ptr u_ptr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (i_cmd),
        .o_resp   (resp)
    );

    lrs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept && resp.wr_en),
        .i_rd_en   (accept && resp.rd_en),
        .i_addr    (resp.addr),
        .i_wr_data (to_store(i_push_value)),
        .o_rd_data (rd_data)
    );

    assign slot_free = !r_out_valid || i_ready;
    assign accept    = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && resp.rd_en) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        ld_value = 1'b0;
        unique case (r_state)
            ST_IDLE: o_ready  = slot_free;
            ST_READ: ld_value = 1'b1;
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = !resp.rd_en;
        end else if (ld_value) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // hold result fields; pop data is loaded from the RAM read in the read state
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= resp.status;
            r_count     <= OCNT_W'(resp.count);
            r_is_empty  <= (resp.count == '0);
            r_pop_value <= '0;
        end else if (ld_value) begin
            r_pop_value <= from_store(rd_data);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pop_value   = r_pop_value;
    assign o_status      = r_status;
    assign o_is_empty    = r_is_empty;
    assign o_entry_count = r_count;

    a_read_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !o_ready)
        else $error("input taken during RAM read");

    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (o_valid && r_state == ST_IDLE))
        else $error("pop result not loaded after read");

    a_pop_goes_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && resp.rd_en) |=> (r_state == ST_READ && !o_valid))
        else $error("pop with data did not start a read");

    a_empty_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_EMPTY) |-> (o_pop_value == '0 && o_is_empty))
        else $error("refused pop returned data");

endmodule
`default_nettype wire
